>>> design/pfs_pkg.sv
// shared types, codes and reset values for the profile fetch sequencer
package pfs_pkg;

    typedef enum logic [1:0] {
        CMD_NONE = 2'd0,
        CMD_ECHO = 2'd1,
        CMD_SET  = 2'd2,
        CMD_GET  = 2'd3
    } cmd_t;

    localparam logic [1:0] KIND_TICK    = 2'd0;
    localparam logic [1:0] KIND_CONNECT = 2'd1;
    localparam logic [1:0] KIND_WRITE   = 2'd2;

    localparam logic [2:0] REG_FETCH_GAP     = 3'd0;
    localparam logic [2:0] REG_RESEND_DELAY  = 3'd1;
    localparam logic [2:0] REG_POLL_START    = 3'd2;
    localparam logic [2:0] REG_POLL_GAP      = 3'd3;
    localparam logic [2:0] REG_POLL_COUNT    = 3'd4;
    localparam logic [2:0] REG_REFETCH_DELAY = 3'd5;
    localparam logic [2:0] REG_UNLOCK_WAIT   = 3'd6;

    localparam logic [15:0] FETCH_GAP_RST     = 16'd80;
    localparam logic [15:0] RESEND_DELAY_RST  = 16'd500;
    localparam logic [15:0] POLL_START_RST    = 16'd1000;
    localparam logic [15:0] POLL_GAP_RST      = 16'd250;
    localparam logic [3:0]  POLL_COUNT_RST    = 4'd6;
    localparam logic [15:0] REFETCH_DELAY_RST = 16'd5500;
    localparam logic [15:0] UNLOCK_WAIT_RST   = 16'd4000;

    localparam logic [3:0] MAX_POLLS = 4'd14;

    localparam logic [7:0] RPT_FETCH_FIRST = 8'h70;
    localparam logic [7:0] RPT_FETCH_LAST  = 8'h7B;
    localparam logic [7:0] RPT_UNLOCK      = 8'h80;
    localparam logic [7:0] RPT_STATUS      = 8'h81;
    localparam logic [7:0] RPT_WRITE_LO    = 8'h60;
    localparam logic [7:0] RPT_WRITE_HI    = 8'h62;
    localparam logic [7:0] RPT_FW_ECHO     = 8'h65;

    typedef struct packed {
        logic [15:0] fetch_gap;
        logic [15:0] resend_delay;
        logic [15:0] poll_start;
        logic [15:0] poll_gap;
        logic [3:0]  poll_count;
        logic [15:0] refetch_delay;
        logic [15:0] unlock_wait;
    } cfg_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] now_ms;
        logic        link_up;
        logic        fw_report_ok;
        logic [7:0]  report_id;
    } event_t;

    typedef struct packed {
        cmd_t       command;
        logic [7:0] target;
    } res_t;

    typedef struct packed {
        logic [1:0] count;
        res_t       first;
        res_t       second;
        logic       ready;
    } step_out_t;

endpackage

>>> design/profile_fetch_sequencer.sv
// top level of the profile fetch sequencer
// An event transaction is captured in an input register and, once the output register
// has room for two, evaluated against the sequencer state in one pass; its zero, one
// or two result transactions go into a two-slot output register that delivers one
// result per cycle while the result side is ready. With the result side ready, an event
// that yields no or one result does not hold up the next, while one that yields two
// holds it until the first result has drained, as the single result port sets the pace.
// Configuration registers are written on cfg_wr_en.
module profile_fetch_sequencer (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_kind,
    input  logic [31:0] s_now_ms,
    input  logic        s_link_up,
    input  logic        s_fw_report_ok,
    input  logic [7:0]  s_report_id,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_command,
    output logic [7:0]  m_target_report,
    output logic        m_profiles_ok,
    output logic        m_last
);
    import pfs_pkg::*;

    cfg_t      cfg;
    step_out_t res;
    event_t    ev_reg;
    logic      ev_valid_reg;
    logic      room;
    logic      fire;

    assign fire    = ev_valid_reg && room;
    assign s_ready = !ev_valid_reg || fire;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ev_valid_reg <= 1'b0;
        end else if (s_ready) begin
            ev_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            ev_reg <= '{kind: s_kind, now_ms: s_now_ms, link_up: s_link_up,
                        fw_report_ok: s_fw_report_ok, report_id: s_report_id};
        end
    end

    pfs_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    pfs_step u_step (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (fire),
        .ev      (ev_reg),
        .cfg     (cfg),
        .res     (res)
    );

    pfs_out_buf u_out (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .load            (fire),
        .res             (res),
        .room            (room),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_command       (m_command),
        .m_target_report (m_target_report),
        .m_profiles_ok   (m_profiles_ok),
        .m_last          (m_last)
    );

endmodule

>>> design/pfs_cfg_regs.sv
// configuration register bank
module pfs_cfg_regs (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           cfg_wr_en,
    input  logic [2:0]     cfg_index,
    input  logic [15:0]    cfg_data,
    output pfs_pkg::cfg_t  cfg
);
    import pfs_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.fetch_gap     <= FETCH_GAP_RST;
            cfg_reg.resend_delay  <= RESEND_DELAY_RST;
            cfg_reg.poll_start    <= POLL_START_RST;
            cfg_reg.poll_gap      <= POLL_GAP_RST;
            cfg_reg.poll_count    <= POLL_COUNT_RST;
            cfg_reg.refetch_delay <= REFETCH_DELAY_RST;
            cfg_reg.unlock_wait   <= UNLOCK_WAIT_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_FETCH_GAP:     cfg_reg.fetch_gap     <= cfg_data;
                REG_RESEND_DELAY:  cfg_reg.resend_delay  <= cfg_data;
                REG_POLL_START:    cfg_reg.poll_start    <= cfg_data;
                REG_POLL_GAP:      cfg_reg.poll_gap      <= cfg_data;
                REG_POLL_COUNT:    cfg_reg.poll_count    <= cfg_data[3:0];
                REG_REFETCH_DELAY: cfg_reg.refetch_delay <= cfg_data;
                REG_UNLOCK_WAIT:   cfg_reg.unlock_wait   <= cfg_data;
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> design/pfs_step.sv
// sequencer state and per-event update logic
module pfs_step (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               fire,
    input  pfs_pkg::event_t    ev,
    input  pfs_pkg::cfg_t      cfg,
    output pfs_pkg::step_out_t res
);
    import pfs_pkg::*;

    logic        unlock_waiting_reg, unlock_waiting_next;
    logic [31:0] unlock_start_reg, unlock_start_next;
    logic        ready_flag_reg, ready_flag_next;
    logic [31:0] write_time_reg, write_time_next;
    logic [3:0]  save_round_reg, save_round_next;
    logic [7:0]  next_fetch_reg, next_fetch_next;
    logic [31:0] last_fetch_reg, last_fetch_next;
    logic        set_ready_reg, set_ready_next;

    logic [3:0]  polls;
    logic [4:0]  polls_p1;
    logic [4:0]  polls_p2;
    logic [31:0] since;
    logic [31:0] fetch_elapsed;
    logic [31:0] unlock_elapsed;
    logic [3:0]  round_m1;
    logic [19:0] poll_offset;
    logic [20:0] poll_thresh;

    assign polls          = (cfg.poll_count > MAX_POLLS) ? MAX_POLLS : cfg.poll_count;
    assign polls_p1       = {1'b0, polls} + 5'd1;
    assign polls_p2       = {1'b0, polls} + 5'd2;
    assign since          = ev.now_ms - write_time_reg;
    assign fetch_elapsed  = ev.now_ms - last_fetch_reg;
    assign unlock_elapsed = ev.now_ms - unlock_start_reg;
    assign round_m1       = save_round_reg - 4'd1;
    assign poll_offset    = cfg.poll_gap * round_m1;
    assign poll_thresh    = {5'd0, cfg.poll_start} + {1'b0, poll_offset};

    always_comb begin
        res_t r0;
        res_t r1;
        logic [1:0] n;
        r0 = '{command: CMD_NONE, target: 8'd0};
        r1 = '{command: CMD_NONE, target: 8'd0};
        n  = 2'd0;

        unlock_waiting_next = unlock_waiting_reg;
        unlock_start_next   = unlock_start_reg;
        ready_flag_next     = ready_flag_reg;
        write_time_next     = write_time_reg;
        save_round_next     = save_round_reg;
        next_fetch_next     = next_fetch_reg;
        last_fetch_next     = last_fetch_reg;
        set_ready_next      = set_ready_reg;

        case (ev.kind)
            KIND_CONNECT: begin
                if (ev.link_up && ev.fw_report_ok) begin
                    r0 = '{command: CMD_ECHO, target: RPT_FW_ECHO};
                    r1 = '{command: CMD_SET, target: RPT_UNLOCK};
                    n  = 2'd2;
                end else begin
                    r0 = '{command: CMD_SET, target: RPT_UNLOCK};
                    n  = 2'd1;
                end
                unlock_start_next   = ev.now_ms;
                unlock_waiting_next = 1'b1;
                ready_flag_next     = 1'b0;
            end
            KIND_WRITE: begin
                if (ev.report_id inside {[RPT_WRITE_LO:RPT_WRITE_HI]}) begin
                    write_time_next = ev.now_ms;
                    save_round_next = 4'd0;
                end
            end
            KIND_TICK: begin
                // paced fetch
                if (next_fetch_reg != 8'd0 && ev.link_up) begin
                    if (fetch_elapsed >= {16'd0, cfg.fetch_gap}) begin
                        last_fetch_next = ev.now_ms;
                        r0 = '{command: CMD_GET, target: next_fetch_reg};
                        n  = 2'd1;
                        if (next_fetch_reg >= RPT_FETCH_LAST) begin
                            next_fetch_next = 8'd0;
                            if (set_ready_reg) begin
                                set_ready_next  = 1'b0;
                                ready_flag_next = 1'b1;
                            end
                        end else begin
                            next_fetch_next = next_fetch_reg + 8'd1;
                        end
                    end
                end else if (next_fetch_reg != 8'd0) begin
                    next_fetch_next = 8'd0;
                    set_ready_next  = 1'b0;
                end

                // post-write schedule
                if (write_time_reg != 32'd0 && ev.link_up) begin
                    if (save_round_reg == 4'd0 && since >= {16'd0, cfg.resend_delay}) begin
                        if (n == 2'd0) r0 = '{command: CMD_SET, target: RPT_UNLOCK};
                        else           r1 = '{command: CMD_SET, target: RPT_UNLOCK};
                        n = n + 2'd1;
                        save_round_next = 4'd1;
                    end else if (save_round_reg >= 4'd1 && save_round_reg <= polls &&
                                 since >= {11'd0, poll_thresh}) begin
                        if (n == 2'd0) r0 = '{command: CMD_GET, target: RPT_STATUS};
                        else           r1 = '{command: CMD_GET, target: RPT_STATUS};
                        n = n + 2'd1;
                        save_round_next = save_round_reg + 4'd1;
                    end else if ({1'b0, save_round_reg} == polls_p1 &&
                                 since >= {16'd0, cfg.refetch_delay}) begin
                        next_fetch_next = RPT_FETCH_FIRST;
                        last_fetch_next = 32'd0;
                        set_ready_next  = 1'b0;
                        save_round_next = polls_p2[3:0];
                        write_time_next = 32'd0;
                    end
                end

                // unlock wait
                if (unlock_waiting_reg) begin
                    if (!ev.link_up) begin
                        unlock_waiting_next = 1'b0;
                        ready_flag_next     = 1'b1;
                    end else if (unlock_elapsed >= {16'd0, cfg.unlock_wait}) begin
                        next_fetch_next     = RPT_FETCH_FIRST;
                        last_fetch_next     = 32'd0;
                        set_ready_next      = 1'b1;
                        unlock_waiting_next = 1'b0;
                    end
                end
            end
            default: ;
        endcase

        res.count  = n;
        res.first  = r0;
        res.second = r1;
        res.ready  = ready_flag_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            unlock_waiting_reg <= 1'b0;
            unlock_start_reg   <= 32'd0;
            ready_flag_reg     <= 1'b1;
            write_time_reg     <= 32'd0;
            save_round_reg     <= 4'd0;
            next_fetch_reg     <= 8'd0;
            last_fetch_reg     <= 32'd0;
            set_ready_reg      <= 1'b0;
        end else if (fire) begin
            unlock_waiting_reg <= unlock_waiting_next;
            unlock_start_reg   <= unlock_start_next;
            ready_flag_reg     <= ready_flag_next;
            write_time_reg     <= write_time_next;
            save_round_reg     <= save_round_next;
            next_fetch_reg     <= next_fetch_next;
            last_fetch_reg     <= last_fetch_next;
            set_ready_reg      <= set_ready_next;
        end
    end

endmodule

>>> design/pfs_out_buf.sv
// two-slot result register that drains one transaction per cycle while m_ready is high
module pfs_out_buf (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                load,
    input  pfs_pkg::step_out_t  res,
    output logic                room,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [1:0]          m_command,
    output logic [7:0]          m_target_report,
    output logic                m_profiles_ok,
    output logic                m_last
);
    import pfs_pkg::*;

    logic [1:0] cnt_reg, cnt_next;
    res_t       slot0_reg, slot0_next;
    res_t       slot1_reg, slot1_next;
    logic       ready_reg, ready_next;
    logic       pop;

    assign pop  = m_valid && m_ready;
    assign room = (cnt_reg == 2'd0) || (cnt_reg == 2'd1 && m_ready);

    always_comb begin
        cnt_next   = cnt_reg;
        slot0_next = slot0_reg;
        slot1_next = slot1_reg;
        ready_next = ready_reg;
        if (load) begin
            cnt_next   = res.count;
            slot0_next = res.first;
            slot1_next = res.second;
            ready_next = res.ready;
        end else if (pop) begin
            cnt_next   = cnt_reg - 2'd1;
            slot0_next = slot1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
        ready_reg <= ready_next;
    end

    assign m_valid         = cnt_reg != 2'd0;
    assign m_command       = slot0_reg.command;
    assign m_target_report = slot0_reg.target;
    assign m_profiles_ok   = ready_reg;
    assign m_last          = cnt_reg == 2'd1;

endmodule

>>> test/testbench.sv
// self-checking testbench for the profile fetch sequencer: directed table, then random events
module testbench;
    import pfs_pkg::*;

    localparam logic [1:0] KIND_UNUSED      = 2'd3;
    localparam int         IDLE_PCT         = 16;
    localparam int         SETTLE_CYCLES    = 8;
    localparam int         STALL_LIMIT      = 2000;
    localparam int         PHASES           = 7;
    localparam int         EVENTS_PER_PHASE = 200;

    typedef struct packed {
        cmd_t       command;
        logic [7:0] target;
        logic       ready;
        logic       last;
    } result_t;

    typedef struct packed {
        event_t     ev;
        logic       typed;
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } plan_row_t;

    localparam result_t NO_RES      = '{CMD_NONE, 8'h00, 1'b0, 1'b0};
    localparam result_t ECHO_HELD   = '{CMD_ECHO, RPT_FW_ECHO, 1'b0, 1'b0};
    localparam result_t UNLOCK_LAST = '{CMD_SET, RPT_UNLOCK, 1'b0, 1'b1};
    localparam result_t FETCH_FIRST = '{CMD_GET, RPT_FETCH_FIRST, 1'b0, 1'b1};
    localparam result_t STATUS_LAST = '{CMD_GET, RPT_STATUS, 1'b0, 1'b1};

    logic        aclk           = 1'b0;
    logic        aresetn        = 1'b0;
    logic        cfg_wr_en      = 1'b0;
    logic [2:0]  cfg_index      = REG_FETCH_GAP;
    logic [15:0] cfg_data       = '0;
    logic        s_valid        = 1'b0;
    logic        s_ready;
    logic [1:0]  s_kind         = KIND_TICK;
    logic [31:0] s_now_ms       = '0;
    logic        s_link_up      = 1'b0;
    logic        s_fw_report_ok = 1'b0;
    logic [7:0]  s_report_id    = '0;
    logic        m_valid;
    logic        m_ready        = 1'b0;
    logic [1:0]  m_command;
    logic [7:0]  m_target_report;
    logic        m_profiles_ok;
    logic        m_last;

    // sequencer state as predicted
    cfg_t        settings = '{FETCH_GAP_RST, RESEND_DELAY_RST, POLL_START_RST, POLL_GAP_RST,
                              POLL_COUNT_RST, REFETCH_DELAY_RST, UNLOCK_WAIT_RST};
    logic        unlock_pending = 1'b0;
    logic [31:0] unlock_t0      = '0;
    logic        ready_now      = 1'b1;
    logic [31:0] write_t0       = '0;
    logic [3:0]  save_step      = '0;
    logic [7:0]  fetch_next     = '0;
    logic [31:0] fetch_t_last   = '0;
    logic        ready_on_done  = 1'b0;

    result_t     pending_commands [$];
    result_t     head;
    int          mismatches = 0;
    bit          calm       = 1'b0;

    plan_row_t plan [24] = '{
        '{'{KIND_TICK,    32'd0,          1'b1, 1'b0, 8'h00}, 1'b1, 2'd0, NO_RES, NO_RES},
        '{'{KIND_UNUSED,  32'hFFFF_FFFF,  1'b1, 1'b1, 8'hFF}, 1'b1, 2'd0, NO_RES, NO_RES},
        '{'{KIND_WRITE,   32'd100,        1'b1, 1'b0, 8'h5F}, 1'b1, 2'd0, NO_RES, NO_RES},
        '{'{KIND_WRITE,   32'd100,        1'b1, 1'b0, 8'h63}, 1'b1, 2'd0, NO_RES, NO_RES},
        '{'{KIND_WRITE,   32'd0,          1'b1, 1'b0, 8'h60}, 1'b1, 2'd0, NO_RES, NO_RES},
        '{'{KIND_TICK,    32'd10000,      1'b1, 1'b0, 8'h00}, 1'b1, 2'd0, NO_RES, NO_RES},
        '{'{KIND_CONNECT, 32'd1000,       1'b1, 1'b1, 8'h00}, 1'b1, 2'd2, ECHO_HELD, UNLOCK_LAST},
        '{'{KIND_CONNECT, 32'd1010,       1'b1, 1'b0, 8'h00}, 1'b1, 2'd1, UNLOCK_LAST, NO_RES},
        '{'{KIND_CONNECT, 32'd1020,       1'b0, 1'b1, 8'h00}, 1'b1, 2'd1, UNLOCK_LAST, NO_RES},
        '{'{KIND_TICK,    32'd1030,       1'b0, 1'b0, 8'h00}, 1'b1, 2'd0, NO_RES, NO_RES},
        '{'{KIND_CONNECT, 32'd2000,       1'b1, 1'b1, 8'h00}, 1'b1, 2'd2, ECHO_HELD, UNLOCK_LAST},
        '{'{KIND_TICK,    32'd5999,       1'b1, 1'b0, 8'h00}, 1'b1, 2'd0, NO_RES, NO_RES},
        '{'{KIND_TICK,    32'd6000,       1'b1, 1'b0, 8'h00}, 1'b1, 2'd0, NO_RES, NO_RES},
        '{'{KIND_TICK,    32'd6100,       1'b1, 1'b0, 8'h00}, 1'b1, 2'd1, FETCH_FIRST, NO_RES},
        '{'{KIND_TICK,    32'd6150,       1'b1, 1'b0, 8'h00}, 1'b0, 2'd0, NO_RES, NO_RES},
        '{'{KIND_TICK,    32'd6180,       1'b1, 1'b0, 8'h00}, 1'b0, 2'd0, NO_RES, NO_RES},
        '{'{KIND_TICK,    32'd6300,       1'b0, 1'b0, 8'h00}, 1'b0, 2'd0, NO_RES, NO_RES},
        '{'{KIND_TICK,    32'd6400,       1'b1, 1'b0, 8'h00}, 1'b0, 2'd0, NO_RES, NO_RES},
        '{'{KIND_WRITE,   32'hFFFF_FF00,  1'b1, 1'b0, 8'h62}, 1'b1, 2'd0, NO_RES, NO_RES},
        '{'{KIND_TICK,    32'h0000_00F0,  1'b0, 1'b0, 8'h00}, 1'b1, 2'd0, NO_RES, NO_RES},
        '{'{KIND_TICK,    32'h0000_00F4,  1'b1, 1'b0, 8'h00}, 1'b1, 2'd1, UNLOCK_LAST, NO_RES},
        '{'{KIND_TICK,    32'h0000_02E8,  1'b1, 1'b0, 8'h00}, 1'b1, 2'd1, STATUS_LAST, NO_RES},
        '{'{KIND_WRITE,   32'hFFFF_FFFF,  1'b1, 1'b1, 8'h61}, 1'b1, 2'd0, NO_RES, NO_RES},
        '{'{KIND_TICK,    32'h0000_01F3,  1'b1, 1'b1, 8'h00}, 1'b0, 2'd0, NO_RES, NO_RES}
    };

    profile_fetch_sequencer u_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_kind           (s_kind),
        .s_now_ms         (s_now_ms),
        .s_link_up        (s_link_up),
        .s_fw_report_ok   (s_fw_report_ok),
        .s_report_id      (s_report_id),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_command        (m_command),
        .m_target_report  (m_target_report),
        .m_profiles_ok    (m_profiles_ok),
        .m_last           (m_last)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // steps the predicted sequencer by one event and optionally queues its commands
    task automatic advance_sequencer(input event_t ev, input bit enqueue);
        cmd_t        cmds [2];
        logic [7:0]  tgts [2];
        int          cnt;
        int          polls;
        logic [31:0] since;
        logic [31:0] poll_due;
        result_t     r;
        cnt   = 0;
        polls = (settings.poll_count > MAX_POLLS) ? int'(MAX_POLLS) : int'(settings.poll_count);
        case (ev.kind)
            KIND_CONNECT: begin
                if (ev.link_up && ev.fw_report_ok) begin
                    cmds[cnt] = CMD_ECHO;
                    tgts[cnt] = RPT_FW_ECHO;
                    cnt++;
                end
                cmds[cnt] = CMD_SET;
                tgts[cnt] = RPT_UNLOCK;
                cnt++;
                unlock_t0      = ev.now_ms;
                unlock_pending = 1'b1;
                ready_now      = 1'b0;
            end
            KIND_WRITE: begin
                if (ev.report_id >= RPT_WRITE_LO && ev.report_id <= RPT_WRITE_HI) begin
                    write_t0  = ev.now_ms;
                    save_step = '0;
                end
            end
            KIND_TICK: begin
                if (fetch_next != 0 && ev.link_up) begin
                    if (ev.now_ms - fetch_t_last >= 32'(settings.fetch_gap)) begin
                        fetch_t_last = ev.now_ms;
                        cmds[cnt] = CMD_GET;
                        tgts[cnt] = fetch_next;
                        cnt++;
                        if (fetch_next >= RPT_FETCH_LAST) begin
                            fetch_next = '0;
                            if (ready_on_done) begin
                                ready_on_done = 1'b0;
                                ready_now     = 1'b1;
                            end
                        end else begin
                            fetch_next = fetch_next + 8'd1;
                        end
                    end
                end else if (fetch_next != 0) begin
                    fetch_next    = '0;
                    ready_on_done = 1'b0;
                end
                if (write_t0 != 0 && ev.link_up) begin
                    since    = ev.now_ms - write_t0;
                    poll_due = 32'(settings.poll_start)
                             + 32'(settings.poll_gap) * (32'(save_step) - 32'd1);
                    if (save_step == 0 && since >= 32'(settings.resend_delay)) begin
                        cmds[cnt] = CMD_SET;
                        tgts[cnt] = RPT_UNLOCK;
                        cnt++;
                        save_step = 4'd1;
                    end else if (save_step >= 1 && int'(save_step) <= polls && since >= poll_due) begin
                        cmds[cnt] = CMD_GET;
                        tgts[cnt] = RPT_STATUS;
                        cnt++;
                        save_step = save_step + 4'd1;
                    end else if (int'(save_step) == polls + 1
                                 && since >= 32'(settings.refetch_delay)) begin
                        // refetch leaves the ready flag alone
                        fetch_next    = RPT_FETCH_FIRST;
                        fetch_t_last  = '0;
                        ready_on_done = 1'b0;
                        save_step     = 4'(polls + 2);
                        write_t0      = '0;
                    end
                end
                if (unlock_pending) begin
                    if (!ev.link_up) begin
                        unlock_pending = 1'b0;
                        ready_now      = 1'b1;
                    end else if (ev.now_ms - unlock_t0 >= 32'(settings.unlock_wait)) begin
                        fetch_next     = RPT_FETCH_FIRST;
                        fetch_t_last   = '0;
                        ready_on_done  = 1'b1;
                        unlock_pending = 1'b0;
                    end
                end
            end
            default: ;
        endcase
        if (enqueue) begin
            for (int k = 0; k < cnt; k++) begin
                r.command = cmds[k];
                r.target  = tgts[k];
                r.ready   = ready_now;
                r.last    = (k == cnt - 1);
                pending_commands.push_back(r);
            end
        end
    endtask

    task automatic send_event(input event_t ev);
        while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_kind         <= ev.kind;
        s_now_ms       <= ev.now_ms;
        s_link_up      <= ev.link_up;
        s_fw_report_ok <= ev.fw_report_ok;
        s_report_id    <= ev.report_id;
        do begin
            @(posedge aclk);
        end while (!s_ready);
    endtask

    task automatic write_register(input logic [2:0] idx, input logic [15:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
    endtask

    task automatic apply_settings(input cfg_t c);
        write_register(REG_FETCH_GAP, c.fetch_gap);
        write_register(REG_RESEND_DELAY, c.resend_delay);
        write_register(REG_POLL_START, c.poll_start);
        write_register(REG_POLL_GAP, c.poll_gap);
        write_register(REG_POLL_COUNT, 16'(c.poll_count));
        write_register(REG_REFETCH_DELAY, c.refetch_delay);
        write_register(REG_UNLOCK_WAIT, c.unlock_wait);
        cfg_wr_en <= 1'b0;
        settings = c;
    endtask

    task automatic drain();
        while (pending_commands.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    function automatic logic [15:0] pick_delay(input int unsigned cap);
        return ($urandom_range(0, 3) == 0) ? 16'($urandom()) : 16'($urandom_range(0, cap));
    endfunction

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_commands.size() == 0) begin
                $error("result transaction with none expected: command %0d target %0h",
                       m_command, m_target_report);
                mismatches++;
            end else begin
                head = pending_commands.pop_front();
                if (m_command !== head.command) begin
                    $error("command: expected %0d, got %0d", head.command, m_command);
                    mismatches++;
                end
                if (m_target_report !== head.target) begin
                    $error("target_report: expected %0h, got %0h", head.target, m_target_report);
                    mismatches++;
                end
                if (m_profiles_ok !== head.ready) begin
                    $error("profiles_ok: expected %0b, got %0b", head.ready, m_profiles_ok);
                    mismatches++;
                end
                if (m_last !== head.last) begin
                    $error("last: expected %0b, got %0b", head.last, m_last);
                    mismatches++;
                end
            end
        end
        m_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    initial begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("profile_fetch_sequencer regression: fail");
        $finish;
    end

    initial begin
        event_t      ev;
        cfg_t        next_cfg;
        logic [31:0] clock_ms;
        int          pick;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // directed table, run with the reset register values
        foreach (plan[i]) begin
            send_event(plan[i].ev);
            advance_sequencer(plan[i].ev, !plan[i].typed);
            if (plan[i].typed && plan[i].count > 0) pending_commands.push_back(plan[i].first);
            if (plan[i].typed && plan[i].count > 1) pending_commands.push_back(plan[i].second);
        end
        s_valid <= 1'b0;
        drain();

        for (int phase = 0; phase < PHASES; phase++) begin
            clock_ms = $urandom_range(1, 5000);
            case (phase)
                0: begin
                    next_cfg = '{FETCH_GAP_RST, RESEND_DELAY_RST, POLL_START_RST, POLL_GAP_RST,
                                 POLL_COUNT_RST, REFETCH_DELAY_RST, UNLOCK_WAIT_RST};
                end
                1: begin
                    next_cfg = '0;
                end
                2: begin
                    next_cfg = '1;
                    clock_ms = 32'hFFFE_0000;
                end
                3: begin
                    next_cfg.fetch_gap     = 16'($urandom_range(0, 40));
                    next_cfg.resend_delay  = 16'($urandom_range(0, 200));
                    next_cfg.poll_start    = 16'($urandom_range(0, 300));
                    next_cfg.poll_gap      = 16'($urandom_range(0, 60));
                    next_cfg.poll_count    = MAX_POLLS;
                    next_cfg.refetch_delay = 16'($urandom_range(0, 1500));
                    next_cfg.unlock_wait   = 16'($urandom_range(0, 800));
                end
                default: begin
                    next_cfg.fetch_gap     = pick_delay(150);
                    next_cfg.resend_delay  = pick_delay(600);
                    next_cfg.poll_start    = pick_delay(1200);
                    next_cfg.poll_gap      = pick_delay(300);
                    next_cfg.poll_count    = 4'($urandom_range(0, 15));
                    next_cfg.refetch_delay = pick_delay(6000);
                    next_cfg.unlock_wait   = pick_delay(4000);
                    if (phase == 5) clock_ms = $urandom();
                end
            endcase
            apply_settings(next_cfg);
            // one phase runs with both sides never idling
            calm = (phase == 3);

            repeat (EVENTS_PER_PHASE) begin
                pick            = $urandom_range(0, 99);
                ev.link_up      = ($urandom_range(0, 15) != 0);
                ev.fw_report_ok = 1'($urandom_range(0, 1));
                ev.report_id    = 8'($urandom_range(0, 255));
                if (pick < 4) begin
                    ev.kind = KIND_CONNECT;
                end else if (pick < 11) begin
                    ev.kind = KIND_WRITE;
                    if ($urandom_range(0, 3) != 0)
                        ev.report_id = 8'($urandom_range(RPT_WRITE_LO, RPT_WRITE_HI));
                end else if (pick < 13) begin
                    ev.kind = KIND_UNUSED;
                end else begin
                    ev.kind = KIND_TICK;
                end
                case ($urandom_range(0, 19))
                    0:       clock_ms = $urandom();
                    1:       clock_ms += 32'($urandom_range(0, 70000));
                    2, 3:    clock_ms += 32'($urandom_range(0, 32'(settings.unlock_wait) / 2 + 2));
                    4, 5:    clock_ms += 32'($urandom_range(0, 32'(settings.refetch_delay) / 2 + 2));
                    6, 7, 8, 9, 10, 11, 12:
                             clock_ms += 32'($urandom_range(0, 32'(settings.fetch_gap) * 2 + 2));
                    default: clock_ms += 32'($urandom_range(0, 32'(settings.poll_gap) * 2 + 2));
                endcase
                ev.now_ms = clock_ms;
                send_event(ev);
                advance_sequencer(ev, 1'b1);
            end
            s_valid <= 1'b0;
            calm = 1'b0;
            drain();
        end

        if (mismatches == 0 && pending_commands.size() == 0)
            $display("profile_fetch_sequencer regression: pass");
        else
            $display("profile_fetch_sequencer regression: fail");
        $finish;
    end

endmodule
